// ===== rtl/core/rccn_pkg.sv =====
// Shared types, constants and normalization tables for the RGB565 center crop normalizer.
package rccn_pkg;

    localparam int CROP_SIZE     = 224;
    localparam int MAX_FRAME_DIM = 1024;

    localparam int CFG_W  = 10;
    localparam int DIM_W  = $clog2(MAX_FRAME_DIM);
    localparam int CNT_W  = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam int POS_W  = CNT_W + 1;
    localparam int OFF_W  = 16;
    localparam int VAL_W  = 16;
    localparam int WORD_W = 16;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SWAP_BYTES   = 2'd2;

    localparam longint RedMeanM   = 485 * 31;
    localparam longint GreenMeanM = 456 * 63;
    localparam longint BlueMeanM  = 406 * 31;
    localparam longint RedDen     = 229 * 31;
    localparam longint GreenDen   = 224 * 63;
    localparam longint BlueDen    = 225 * 31;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } ch_t;

    typedef struct packed {
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
        logic             swap_bytes;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [OFF_W-1:0]  offset;
        logic              last;
    } item_t;

    typedef struct packed {
        logic valid;
        logic full;
    } qstat_t;

    typedef logic signed [VAL_W-1:0] lut5_t [32];
    typedef logic signed [VAL_W-1:0] lut6_t [64];

    // Magnitude rounded to nearest, ties away from zero.
    function automatic longint div_round(longint mag, ch_t ch);
        longint q;
        case (ch)
            CH_RED:   q = (mag + RedDen / 2) / RedDen;
            CH_GREEN: q = (mag + GreenDen / 2) / GreenDen;
            CH_BLUE:  q = (mag + BlueDen / 2) / BlueDen;
            default:  q = 0;
        endcase
        return q;
    endfunction

    function automatic logic signed [VAL_W-1:0] norm_q312(int v, ch_t ch);
        longint num;
        longint q;
        case (ch)
            CH_RED:   num = 4096 * (1000 * longint'(v) - RedMeanM);
            CH_GREEN: num = 4096 * (1000 * longint'(v) - GreenMeanM);
            CH_BLUE:  num = 4096 * (1000 * longint'(v) - BlueMeanM);
            default:  num = 0;
        endcase
        if (num >= 0) begin
            q = div_round(num, ch);
        end else begin
            q = -div_round(-num, ch);
        end
        if (q > 32767) begin
            q = 32767;
        end
        if (q < -32768) begin
            q = -32768;
        end
        return VAL_W'(q);
    endfunction

    function automatic lut5_t build_lut5(ch_t ch);
        lut5_t t;
        for (int i = 0; i < 32; i++) begin
            t[i] = norm_q312(i, ch);
        end
        return t;
    endfunction

    function automatic lut6_t build_lut6(ch_t ch);
        lut6_t t;
        for (int i = 0; i < 64; i++) begin
            t[i] = norm_q312(i, ch);
        end
        return t;
    endfunction

endpackage

// ===== rtl/core/rccn_front.sv =====
// Front end: pixel position tracking, crop classification, byte swap.
module rccn_front import rccn_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  qstat_t      q_stat,
    output logic        q_push,
    output item_t       q_item
);

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] col, row;
    logic [POS_W-1:0] fw_x, fh_x, col_x, row_x, cx, cy, row_cap;
    logic             accept, fit, in_crop, wrap;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        col     = s_tuser[0] ? '0 : col_reg;
        row     = s_tuser[0] ? '0 : row_reg;
        fw_x    = POS_W'(cfg.frame_width);
        fh_x    = POS_W'(cfg.frame_height);
        col_x   = POS_W'(col);
        row_x   = POS_W'(row);
        fit     = (fw_x >= POS_W'(CROP_SIZE)) && (fh_x >= POS_W'(CROP_SIZE));
        cx      = (fw_x - POS_W'(CROP_SIZE)) >> 1;
        cy      = (fh_x - POS_W'(CROP_SIZE)) >> 1;
        in_crop = fit && (col_x >= cx) && (col_x < cx + POS_W'(CROP_SIZE))
                      && (row_x >= cy) && (row_x < cy + POS_W'(CROP_SIZE));

        q_item.word   = cfg.swap_bytes ? {s_tdata[7:0], s_tdata[15:8]} : s_tdata;
        q_item.offset = OFF_W'(row_x - cy) * OFF_W'(CROP_SIZE) + OFF_W'(col_x - cx);
        q_item.last   = (col_x == cx + POS_W'(CROP_SIZE - 1))
                     && (row_x == cy + POS_W'(CROP_SIZE - 1));
        q_push        = accept && in_crop;

        row_cap  = (fh_x > POS_W'(MAX_FRAME_DIM - 1)) ? POS_W'(MAX_FRAME_DIM - 1) : fh_x;
        wrap     = (col_x + POS_W'(1)) >= fw_x;
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (wrap) begin
                col_next = '0;
                row_next = (row_x < row_cap) ? CNT_W'(row_x + POS_W'(1)) : row;
            end else begin
                col_next = CNT_W'(col_x + POS_W'(1));
                row_next = row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== rtl/core/rccn_queue.sv =====
// Two-entry request queue between front end and back end.
module rccn_queue import rccn_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  item_t  push_item,
    input  logic   pop,
    output item_t  pop_item,
    output qstat_t stat
);

    item_t      mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign stat.valid = (count_reg != 2'd0);
    assign stat.full  = (count_reg == 2'd2);
    assign pop_item   = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/rccn_back.sv =====
// Back end: per-channel normalization tables and result output register.
module rccn_back import rccn_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  qstat_t      q_stat,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic        m_tlast
);

    localparam lut5_t RedLut   = build_lut5(CH_RED);
    localparam lut6_t GreenLut = build_lut6(CH_GREEN);
    localparam lut5_t BlueLut  = build_lut5(CH_BLUE);

    logic              valid_reg;
    logic [63:0]       data_reg;
    logic              last_reg;
    logic [63:0]       data_next;

    assign q_pop    = q_stat.valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    always_comb begin
        data_next = {q_item.offset,
                     BlueLut[q_item.word[4:0]],
                     GreenLut[q_item.word[10:5]],
                     RedLut[q_item.word[15:11]]};
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= data_next;
            last_reg <= q_item.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

endmodule

// ===== rtl/core/rgb565_center_crop_normalizer_core.sv =====
// Top level: config registers, front end, request queue and back end.
//
// Input stream: s_tdata carries one RGB565 pixel word per request, raster order;
// s_tuser flags the first pixel of a frame. Every request is consumed; only
// pixels inside the centered CROP_SIZE square produce a result request.
// Output stream: m_tdata carries red, green and blue as signed Q3.12 plus the
// planar element offset; m_tlast marks the bottom-right pixel of the crop.
// Frames narrower or shorter than the crop produce no results.
// Throughput: one pixel per cycle while m_tready is high, set by the combinational
// position and crop compare in the front end and the table lookup in the back end.
// A result is valid once its pixel has passed a queue entry and the output register.
// A two-entry queue separates the ends; while m_tready is low, results hold
// in the output register, the queue fills and s_tready drops once it is full.
// Reset clears position, queue and output valid; registers return to
// 320 x 240 with byte swap on. Registers are written over APB:
// 0x0 frame width, 0x4 frame height, 0x8 byte swap. pready is always high.
module rgb565_center_crop_normalizer_core import rccn_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // pixel_word
    input  logic [0:0]  s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // red_norm, green_norm, blue_norm, plane_offset
    output logic        m_tlast    // crop_last
);

    cfg_t   cfg_reg;
    qstat_t q_stat;
    item_t  push_item, pop_item;
    logic   q_push, q_pop;
    logic   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width  <= CFG_W'(320);
            cfg_reg.frame_height <= CFG_W'(240);
            cfg_reg.swap_bytes   <= 1'b1;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= pwdata[CFG_W-1:0];
                REG_SWAP_BYTES:   cfg_reg.swap_bytes   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = 32'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT: prdata = 32'(cfg_reg.frame_height);
            REG_SWAP_BYTES:   prdata = 32'(cfg_reg.swap_bytes);
            default:          prdata = 32'd0;
        endcase
    end

    rccn_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    rccn_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .stat      (q_stat)
    );

    rccn_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_push_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (s_tvalid && s_tready))
        else $error("queue request without input accept");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_stat.valid)
        else $error("queue pop while empty");

    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> !s_tready)
        else $error("input ready while queue full");

    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule

// ===== tb/rgb565_center_crop_normalizer_core_test.sv =====
// Self-checking testbench for the RGB565 center crop normalizer: random stream, scoreboard.
module rgb565_center_crop_normalizer_core_test;
    import rccn_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic signed [15:0] red;
        logic signed [15:0] green;
        logic signed [15:0] blue;
        logic [15:0]        offset;
        logic               last;
    } crop_pixel_t;

    class crop_scoreboard;
        logic [9:0]  width  = 10'd320;
        logic [9:0]  height = 10'd240;
        logic        swap   = 1'b1;
        logic [9:0]  col    = '0;
        logic [9:0]  row    = '0;
        crop_pixel_t expected_pixels[$];
        int          errors;
        int          results_seen;

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_FRAME_WIDTH:  width  = val[9:0];
                REG_FRAME_HEIGHT: height = val[9:0];
                REG_SWAP_BYTES:   swap   = val[0];
                default: ;
            endcase
        endfunction

        // (level/full - mean)/std in Q3.12, mean and std in thousandths
        function logic signed [15:0] to_q312(int level, int full, int mean_k, int std_k);
            longint num;
            longint den;
            longint mag;
            longint q;
            num = 64'sd4096 * (longint'(level) * 1000 - longint'(mean_k) * full);
            den = longint'(std_k) * full;
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            if (num < 0) begin
                q = -q;
            end
            if (q > 32767) begin
                q = 32767;
            end else if (q < -32768) begin
                q = -32768;
            end
            return q[15:0];
        endfunction

        function void note_pixel(logic [15:0] word, logic first);
            int          c;
            int          r;
            int          wi;
            int          hi;
            int          cx;
            int          cy;
            int          cap;
            logic [15:0] p;
            crop_pixel_t e;
            if (first) begin
                col = '0;
                row = '0;
            end
            c = col;
            r = row;
            wi = width;
            hi = height;
            if (wi >= CROP_SIZE && hi >= CROP_SIZE) begin
                cx = (wi - CROP_SIZE) / 2;
                cy = (hi - CROP_SIZE) / 2;
                if (c >= cx && c < cx + CROP_SIZE && r >= cy && r < cy + CROP_SIZE) begin
                    p = swap ? {word[7:0], word[15:8]} : word;
                    e.red    = to_q312(p[15:11], 31, 485, 229);
                    e.green  = to_q312(p[10:5], 63, 456, 224);
                    e.blue   = to_q312(p[4:0], 31, 406, 225);
                    e.offset = 16'((r - cy) * CROP_SIZE + (c - cx));
                    e.last   = (c == cx + CROP_SIZE - 1) && (r == cy + CROP_SIZE - 1);
                    expected_pixels.push_back(e);
                end
            end
            cap = (hi > MAX_FRAME_DIM - 1) ? MAX_FRAME_DIM - 1 : hi;
            if (c + 1 >= wi) begin
                col = '0;
                if (r < cap) begin
                    row = 10'(r + 1);
                end
            end else begin
                col = 10'(c + 1);
            end
        endfunction

        function void flag(string field, longint exp_v, longint act_v);
            $error("%s: expected %0d, got %0d", field, exp_v, act_v);
            errors++;
        endfunction

        function void check_result(logic [63:0] data, logic last);
            crop_pixel_t e;
            results_seen++;
            if (expected_pixels.size() == 0) begin
                $error("result with none expected: data %h last %b", data, last);
                errors++;
                return;
            end
            e = expected_pixels.pop_front();
            if (data[15:0] !== e.red) begin
                flag("red_norm", e.red, $signed(data[15:0]));
            end
            if (data[31:16] !== e.green) begin
                flag("green_norm", e.green, $signed(data[31:16]));
            end
            if (data[47:32] !== e.blue) begin
                flag("blue_norm", e.blue, $signed(data[47:32]));
            end
            if (data[63:48] !== e.offset) begin
                flag("plane_offset", e.offset, data[63:48]);
            end
            if (last !== e.last) begin
                flag("crop_last", e.last, last);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // pixel_word
    logic [0:0]  s_tuser  = '0;   // frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [63:0] m_tdata;         // red_norm, green_norm, blue_norm, plane_offset
    logic        m_tlast;         // crop_last

    crop_scoreboard sb = new();
    bit             idle_on = 1'b1;
    int             items_sent;
    int             stall_left;

    rgb565_center_crop_normalizer_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tlast);
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_pixel(input logic [15:0] word, input logic first);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(word, first);
        items_sent++;
    endtask

    // all requests out, every result back, then let the pipeline settle
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Width 1 walks the row counter down quickly (no crop possible), then the real width
    // is switched in so the stream lands at a chosen row of the crop.
    task automatic run_window(input int w, input int h, input bit swap, input int skip,
                              input int n, input int restart_rate);
        bit first;
        wait_results_done();
        write_reg(REG_FRAME_HEIGHT, 32'(h));
        write_reg(REG_SWAP_BYTES, 32'(swap));
        if (skip > 0) begin
            write_reg(REG_FRAME_WIDTH, 32'd1);
            for (int i = 0; i < skip; i++) begin
                send_pixel(16'($urandom_range(0, 65535)), i == 0);
            end
            wait_results_done();
        end
        write_reg(REG_FRAME_WIDTH, 32'(w));
        for (int i = 0; i < n; i++) begin
            first = (i == 0 && skip == 0) ||
                    (restart_rate != 0 && $urandom_range(0, restart_rate - 1) == 0);
            send_pixel(16'($urandom_range(0, 65535)), first);
        end
    endtask

    function automatic int crop_dim();
        if ($urandom_range(0, 9) == 0) begin
            return CROP_SIZE + $urandom_range(17, 120);
        end
        return CROP_SIZE + $urandom_range(0, 16);
    endfunction

    task automatic well_formed_window(input bit at_bottom);
        int w;
        int h;
        int cy;
        int k;
        w  = crop_dim();
        h  = crop_dim();
        cy = (h - CROP_SIZE) / 2;
        k  = $urandom_range(1, 3);
        if (at_bottom) begin
            run_window(w, h, $urandom_range(0, 1), cy + CROP_SIZE - k,
                       k * w + $urandom_range(0, 6), 400);
        end else begin
            run_window(w, h, $urandom_range(0, 1), cy + $urandom_range(0, 2),
                       k * w + $urandom_range(0, 6), 400);
        end
    endtask

    initial begin
        logic [15:0] corner_words[8];
        int          h;

        corner_words = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0,
                         16'h001F, 16'h00F8, 16'hE007, 16'h1F00};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // crop covers the whole frame, so every pixel gives a result
        write_reg(REG_FRAME_WIDTH, 32'(CROP_SIZE));
        write_reg(REG_FRAME_HEIGHT, 32'(CROP_SIZE));
        idle_on = 1'b0;
        foreach (corner_words[i]) begin
            send_pixel(corner_words[i], i == 0);
        end
        wait_results_done();
        write_reg(REG_SWAP_BYTES, 32'd0);
        foreach (corner_words[i]) begin
            send_pixel(corner_words[i], i == 0);
        end
        send_pixel(16'h1234, 1'b1);
        wait_results_done();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        // frames below the crop size
        write_reg(REG_FRAME_WIDTH, 32'(CROP_SIZE - 1));
        send_pixel(16'hA5A5, 1'b1);
        send_pixel(16'h5A5A, 1'b0);
        wait_results_done();
        write_reg(REG_FRAME_WIDTH, 32'd0);
        send_pixel(16'h8001, 1'b1);
        send_pixel(16'h7FFE, 1'b0);
        idle_on = 1'b1;

        // largest frame once: bottom row of its crop
        run_window(1023, 1023, $urandom_range(0, 1), 399 + CROP_SIZE - 1, 1023 + 8, 0);

        while (items_sent < 2000 || sb.results_seen < 48) begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3:  well_formed_window(1'b0);
                4, 5, 6:     well_formed_window(1'b1);
                7: begin
                    // below crop in one dimension
                    if ($urandom_range(0, 1) == 1) begin
                        run_window($urandom_range(0, CROP_SIZE - 1), crop_dim(),
                                   $urandom_range(0, 1), $urandom_range(0, 10), 60, 20);
                    end else begin
                        run_window(crop_dim(), $urandom_range(0, CROP_SIZE - 1),
                                   $urandom_range(0, 1), $urandom_range(0, 10), 60, 20);
                    end
                end
                8: begin
                    // walk past the frame end; row sticks at the height
                    h = CROP_SIZE + $urandom_range(0, 8);
                    run_window(crop_dim(), h, $urandom_range(0, 1),
                               h + $urandom_range(0, 4), 40, 0);
                end
                9: begin
                    run_window($urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom_range(0, 1), $urandom_range(0, 20), 64, 8);
                end
                default: begin
                    run_window(CROP_SIZE, CROP_SIZE, $urandom_range(0, 1), 0,
                               $urandom_range(20, 200), 50);
                end
            endcase
        end

        idle_on = 1'b0;
        run_window(CROP_SIZE, CROP_SIZE, $urandom_range(0, 1), CROP_SIZE - 2,
                   2 * CROP_SIZE + 4, 0);
        wait_results_done();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rccn_pkg.sv
rtl/core/rccn_front.sv
rtl/core/rccn_queue.sv
rtl/core/rccn_back.sv
rtl/core/rgb565_center_crop_normalizer_core.sv
tb/rgb565_center_crop_normalizer_core_test.sv
